// ===== sv/rvq_pkg.sv =====
// shared types, constants and elaboration-time table functions for the rotation vector block
`default_nettype none
package rvq_pkg;

    localparam int W_W     = 32;
    localparam int THETA_W = 32;
    localparam int SUM_W   = 64;
    localparam int XY_W    = 36;
    localparam int LIMIT_W = 31;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd2684355;
    localparam logic [63:0]        PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic signed [31:0] SAT_ONE     = 32'sd1073741824;

    typedef logic signed [W_W-1:0]  comp_t;
    typedef logic [2:0][W_W-1:0]    vec_t;
    typedef logic [THETA_W-1:0]     theta_t;
    typedef logic signed [XY_W-1:0] xy_t;

    typedef struct packed {
        logic  is_small;
        comp_t qw;
        vec_t  q;
    } result_t;

    function automatic comp_t sat30(input logic signed [63:0] v);
        if (v > 64'sd1073741824) begin
            return SAT_ONE;
        end
        else if (v < -64'sd1073741824) begin
            return -SAT_ONE;
        end
        return comp_t'(v[31:0]);
    endfunction

    // restoring long division, constant use only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        acc  = '0;
        term = '0;
        if (i == 0) begin
            return PI_Q60;
        end
        for (int k = 0; k < 32; k++) begin
            if (i * (2 * k + 1) <= 62) begin
                term = udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - term;
                end
                else begin
                    acc = acc + term;
                end
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] q62_to_angle(input logic [63:0] a, input int afrac);
        return (a + (64'd1 << (61 - afrac))) >> (62 - afrac);
    endfunction

    function automatic logic [63:0] cordic_gain_q32(input int iters);
        logic [63:0] p;
        logic [63:0] s;
        p = 64'd1 << 62;
        for (int i = 0; i < 64; i++) begin
            if (i < iters && 2 * i < 64) begin
                p = p + (p >> (2 * i));
            end
        end
        s = isqrt64(p);
        return udiv64((64'd1 << 63) + (s >> 1), s);
    endfunction

endpackage
`default_nettype wire

// ===== sv/rvq_norm.sv =====
// vector norm: squares, sum and a one-bit-per-stage square root pipeline
`default_nettype none
module rvq_norm
    import rvq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  vec_t   in_w,
    output logic   out_valid,
    output vec_t   out_w,
    output theta_t out_theta
);

    localparam int NS = THETA_W;

    logic [W_W-1:0]   mag [3];
    logic             sq_valid_reg;
    vec_t             sq_w_reg;
    logic [SUM_W-1:0] sq_reg [3];
    logic [SUM_W-1:0] sum_next;

    logic             rt_valid_reg [NS+1];
    vec_t             rt_w_reg [NS+1];
    logic [SUM_W-1:0] rem_reg [NS];
    theta_t           root_reg [NS+1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = in_w[k][W_W-1] ? (~in_w[k] + 1'b1) : in_w[k];
        end
    end

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg    <= 1'b0;
            rt_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg    <= in_valid;
            rt_valid_reg[0] <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_w_reg <= in_w;
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= SUM_W'(mag[k]) * SUM_W'(mag[k]);
            end
            rt_w_reg[0] <= sq_w_reg;
            rem_reg[0]  <= sum_next;
            root_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_root
        localparam int B = NS - 1 - j;
        logic [SUM_W-1:0] trial;
        logic             fits;

        assign trial = ((SUM_W'(root_reg[j]) << 1) + (SUM_W'(1) << B)) << B;
        assign fits  = rem_reg[j] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_valid_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                rt_valid_reg[j+1] <= rt_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_w_reg[j+1] <= rt_w_reg[j];
                root_reg[j+1] <= fits ? (root_reg[j] | (theta_t'(1) << B)) : root_reg[j];
            end
        end

        if (j < NS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[j+1] <= fits ? (rem_reg[j] - trial) : rem_reg[j];
                end
            end
        end
    end

    assign out_valid = rt_valid_reg[NS];
    assign out_w     = rt_w_reg[NS];
    assign out_theta = root_reg[NS];

endmodule
`default_nettype wire

// ===== sv/rvq_cordic.sv =====
// half-angle scaling, range reduction and pipelined rotation-mode cordic
`default_nettype none
module rvq_cordic
    import rvq_pkg::*;
#(
    parameter int ANGLE_WIDTH     = 32,
    parameter int TRIG_ITERATIONS = 24
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  vec_t   in_w,
    input  theta_t in_theta,
    output logic   out_valid,
    output vec_t   out_w,
    output theta_t out_theta,
    output xy_t    out_x,
    output xy_t    out_y,
    output logic   out_flip
);

    localparam int AFRAC = ANGLE_WIDTH - 3;
    localparam int ZW    = ANGLE_WIDTH + 2;
    localparam int NI    = TRIG_ITERATIONS;
    localparam int HSHL  = (AFRAC >= 29) ? AFRAC - 29 : 0;
    localparam int HSHR  = (AFRAC >= 29) ? 0 : 29 - AFRAC;
    localparam logic [63:0] HRND  = (64'd1 << HSHR) >> 1;
    localparam logic [63:0] PI64  = (PI_Q60 + (64'd1 << (59 - AFRAC))) >> (60 - AFRAC);
    localparam logic [63:0] HPI64 = (PI_Q60 + (64'd1 << (60 - AFRAC))) >> (61 - AFRAC);
    localparam logic signed [ZW-1:0] PI_Z      = ZW'(PI64);
    localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(PI64 << 1);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HPI64);
    localparam xy_t GAIN = XY_W'(cordic_gain_q32(NI));

    logic [63:0]            h64;
    logic signed [ZW-1:0]   h;
    logic signed [ZW-1:0]   h_wrap;
    logic                   r1_valid_reg;
    logic signed [ZW-1:0]   r1_h_reg;
    theta_t                 r1_theta_reg;
    vec_t                   r1_w_reg;
    logic signed [ZW-1:0]   z_next;
    logic                   flip_next;

    logic                   valid_reg [NI+1];
    xy_t                    x_reg [NI+1];
    xy_t                    y_reg [NI+1];
    logic signed [ZW-1:0]   z_reg [NI];
    logic                   flip_reg [NI+1];
    theta_t                 theta_reg [NI+1];
    vec_t                   w_reg [NI+1];

    assign h64    = ((64'(in_theta) + HRND) >> HSHR) << HSHL;
    assign h      = ZW'(h64);
    assign h_wrap = (h > PI_Z) ? (h - TWO_PI_Z) : h;

    always_comb
    begin
        z_next    = r1_h_reg;
        flip_next = 1'b0;
        if (r1_h_reg > HALF_PI_Z)
        begin
            z_next    = r1_h_reg - PI_Z;
            flip_next = 1'b1;
        end
        else if (r1_h_reg < -HALF_PI_Z)
        begin
            z_next    = r1_h_reg + PI_Z;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            r1_valid_reg <= in_valid;
            valid_reg[0] <= r1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_h_reg     <= h_wrap;
            r1_theta_reg <= in_theta;
            r1_w_reg     <= in_w;
            x_reg[0]     <= GAIN;
            y_reg[0]     <= '0;
            z_reg[0]     <= z_next;
            flip_reg[0]  <= flip_next;
            theta_reg[0] <= r1_theta_reg;
            w_reg[0]     <= r1_w_reg;
        end
    end

    for (genvar i = 0; i < NI; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(q62_to_angle(atan_q62(i), AFRAC));
        xy_t  dx;
        xy_t  dy;
        logic pos;

        assign dx  = y_reg[i] >>> i;
        assign dy  = x_reg[i] >>> i;
        assign pos = !z_reg[i][ZW-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i+1]     <= pos ? (x_reg[i] - dx) : (x_reg[i] + dx);
                y_reg[i+1]     <= pos ? (y_reg[i] + dy) : (y_reg[i] - dy);
                flip_reg[i+1]  <= flip_reg[i];
                theta_reg[i+1] <= theta_reg[i];
                w_reg[i+1]     <= w_reg[i];
            end
        end

        if (i < NI - 1)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    z_reg[i+1] <= pos ? (z_reg[i] - ATAN_I) : (z_reg[i] + ATAN_I);
                end
            end
        end
    end

    assign out_valid = valid_reg[NI];
    assign out_w     = w_reg[NI];
    assign out_theta = theta_reg[NI];
    assign out_x     = x_reg[NI];
    assign out_y     = y_reg[NI];
    assign out_flip  = flip_reg[NI];

endmodule
`default_nettype wire

// ===== sv/rvq_scale.sv =====
// scalar part, branch select, shared multipliers and pipelined dividers for the vector part
`default_nettype none
module rvq_scale
    import rvq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [LIMIT_W-1:0] limit,
    input  logic               in_valid,
    input  vec_t               in_w,
    input  theta_t             in_theta,
    input  xy_t                in_x,
    input  xy_t                in_y,
    input  logic               in_flip,
    output logic               out_valid,
    output result_t            out_res
);

    localparam int QB    = 32;
    localparam int NUM_W = 66;
    localparam int DEN_W = THETA_W + 2;
    localparam int A_W   = 34;
    localparam int B_W   = W_W + 1;
    localparam int P_W   = A_W + B_W;

    logic               p1_valid_reg;
    xy_t                p1_c_reg;
    xy_t                p1_s_reg;
    logic               p1_small_reg;
    theta_t             p1_theta_reg;
    vec_t               p1_w_reg;

    comp_t              qw_next;
    xy_t                s_abs;
    logic               p2_valid_reg;
    logic signed [A_W-1:0] p2_a_reg;
    logic signed [B_W-1:0] p2_b_reg [3];
    comp_t              p2_qw_reg;
    logic               p2_small_reg;
    logic [2:0]         p2_neg_reg;
    theta_t             p2_theta_reg;

    logic               p3_valid_reg;
    logic signed [P_W-1:0] p3_prod_reg [3];
    comp_t              p3_qw_reg;
    logic               p3_small_reg;
    logic [2:0]         p3_neg_reg;
    theta_t             p3_theta_reg;

    vec_t               sres_next;
    logic [NUM_W-1:0]   num_next [3];

    logic               dv_valid_reg [QB+1];
    logic [NUM_W-1:0]   rem_reg [QB][3];
    logic [DEN_W-1:0]   den_reg [QB];
    logic [QB-1:0]      quo_reg [QB+1][3];
    vec_t               sres_reg [QB+1];
    comp_t              qw_reg [QB+1];
    logic               small_reg [QB+1];
    logic [2:0]         neg_reg [QB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            p3_valid_reg    <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg    <= in_valid;
            p2_valid_reg    <= p1_valid_reg;
            p3_valid_reg    <= p2_valid_reg;
            dv_valid_reg[0] <= p3_valid_reg;
        end
    end

    // stage 1: undo the quadrant flip, pick the branch
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_c_reg     <= in_flip ? -in_x : in_x;
            p1_s_reg     <= in_flip ? -in_y : in_y;
            p1_small_reg <= (in_theta < {1'b0, limit}) || (in_theta == '0);
            p1_theta_reg <= in_theta;
            p1_w_reg     <= in_w;
        end
    end

    // stage 2: scalar part and multiplier operands
    assign qw_next = sat30((64'(p1_c_reg) + 64'sd2) >>> 2);
    assign s_abs   = p1_s_reg[XY_W-1] ? -p1_s_reg : p1_s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_a_reg     <= p1_small_reg ? A_W'(qw_next) : A_W'(s_abs);
            p2_qw_reg    <= qw_next;
            p2_small_reg <= p1_small_reg;
            p2_theta_reg <= p1_theta_reg;
            for (int k = 0; k < 3; k++)
            begin
                if (p1_small_reg)
                begin
                    p2_b_reg[k] <= B_W'(comp_t'(p1_w_reg[k]));
                end
                else
                begin
                    p2_b_reg[k] <= p1_w_reg[k][W_W-1] ? {1'b0, ~p1_w_reg[k] + 1'b1}
                                                      : {1'b0, p1_w_reg[k]};
                end
                p2_neg_reg[k] <= p1_s_reg[XY_W-1] ^ p1_w_reg[k][W_W-1];
            end
        end
    end

    // stage 3: products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p3_prod_reg[k] <= p2_a_reg * p2_b_reg[k];
            end
            p3_qw_reg    <= p2_qw_reg;
            p3_small_reg <= p2_small_reg;
            p3_neg_reg   <= p2_neg_reg;
            p3_theta_reg <= p2_theta_reg;
        end
    end

    // stage 4: small-angle result and divider setup
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sres_next[k] = sat30(64'((p3_prod_reg[k] + P_W'(268435456)) >>> 29));
            num_next[k]  = NUM_W'(p3_prod_reg[k]) + NUM_W'({p3_theta_reg, 1'b0});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[0][k] <= num_next[k];
                quo_reg[0][k] <= '0;
            end
            den_reg[0]   <= {p3_theta_reg, 2'b00};
            sres_reg[0]  <= sres_next;
            qw_reg[0]    <= p3_qw_reg;
            small_reg[0] <= p3_small_reg;
            neg_reg[0]   <= p3_neg_reg;
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int B = QB - 1 - j;
        logic [NUM_W-1:0] trial;
        logic [2:0]       fits;

        assign trial = NUM_W'(den_reg[j]) << B;

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                fits[k] = rem_reg[j][k] >= trial;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    quo_reg[j+1][k] <= quo_reg[j][k] | (QB'(fits[k]) << B);
                end
                sres_reg[j+1]  <= sres_reg[j];
                qw_reg[j+1]    <= qw_reg[j];
                small_reg[j+1] <= small_reg[j];
                neg_reg[j+1]   <= neg_reg[j];
            end
        end

        if (j < QB - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        rem_reg[j+1][k] <= fits[k] ? (rem_reg[j][k] - trial) : rem_reg[j][k];
                    end
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end
    end

    // final select and saturation
    always_comb
    begin
        logic [QB-1:0] v;
        v = '0;
        out_res.is_small = small_reg[QB];
        out_res.qw       = qw_reg[QB];
        for (int k = 0; k < 3; k++)
        begin
            v = (quo_reg[QB][k] > 32'd1073741824) ? 32'd1073741824 : quo_reg[QB][k];
            if (small_reg[QB])
            begin
                out_res.q[k] = sres_reg[QB][k];
            end
            else
            begin
                out_res.q[k] = neg_reg[QB][k] ? -v : v;
            end
        end
    end

    assign out_valid = dv_valid_reg[QB];

endmodule
`default_nettype wire

// ===== sv/rotation_vector_to_quaternion.sv =====
// top level: rotation vector to unit quaternion, config register and output buffer
//
// Streams rotation vectors (signed Q3.28) in and unit quaternions (signed Q1.30,
// saturated to +-1.0) out, one transfer per cycle when neither side stalls. Results
// pass in order through the norm (squares, sum, a 32-stage square root), range
// reduction and the cordic, the scalar part, the multipliers and the 32-stage
// dividers, and the output register. small_angle_used marks results whose vector
// part is qw * w / 2. A two-entry output buffer holds results while out_stall is
// high; in_stall rises once both entries are full and the whole pipeline holds
// until one drains. Write small_angle_limit only while no transfer is in flight.
`default_nettype none
module rotation_vector_to_quaternion
    import rvq_pkg::*;
#(
    parameter int ANGLE_WIDTH     = 32,
    parameter int TRIG_ITERATIONS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] wx,
    input  logic signed [31:0] wy,
    input  logic signed [31:0] wz,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] quat_w,
    output logic signed [31:0] quat_x,
    output logic signed [31:0] quat_y,
    output logic signed [31:0] quat_z,
    output logic               small_angle_used
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               adv;
    vec_t               in_w;

    logic               nm_valid;
    vec_t               nm_w;
    theta_t             nm_theta;
    logic               cd_valid;
    vec_t               cd_w;
    theta_t             cd_theta;
    xy_t                cd_x;
    xy_t                cd_y;
    logic               cd_flip;
    logic               sc_valid;
    result_t            sc_res;

    logic               head_valid_reg;
    logic               head_valid_next;
    result_t            head_reg;
    result_t            head_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    result_t            skid_reg;
    result_t            skid_next;
    logic               push;
    logic               pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign in_w     = {wz, wy, wx};

    rvq_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_w      (in_w),
        .out_valid (nm_valid),
        .out_w     (nm_w),
        .out_theta (nm_theta)
    );

    rvq_cordic #(
        .ANGLE_WIDTH     (ANGLE_WIDTH),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (nm_valid),
        .in_w      (nm_w),
        .in_theta  (nm_theta),
        .out_valid (cd_valid),
        .out_w     (cd_w),
        .out_theta (cd_theta),
        .out_x     (cd_x),
        .out_y     (cd_y),
        .out_flip  (cd_flip)
    );

    rvq_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .limit     (limit_reg),
        .in_valid  (cd_valid),
        .in_w      (cd_w),
        .in_theta  (cd_theta),
        .in_x      (cd_x),
        .in_y      (cd_y),
        .in_flip   (cd_flip),
        .out_valid (sc_valid),
        .out_res   (sc_res)
    );

    // two-entry output buffer
    assign push = sc_valid && adv;
    assign pop  = head_valid_reg && !out_stall;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (head_valid_reg)
        begin
            if (pop && push)
            begin
                head_next = sc_res;
            end
            else if (pop)
            begin
                head_valid_next = 1'b0;
            end
            else if (push)
            begin
                skid_next       = sc_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (push)
        begin
            head_next       = sc_res;
            head_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid        = head_valid_reg;
    assign quat_w           = head_reg.qw;
    assign quat_x           = head_reg.q[0];
    assign quat_y           = head_reg.q[1];
    assign quat_z           = head_reg.q[2];
    assign small_angle_used = head_reg.is_small;

    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held without a head entry");

    a_full_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> head_valid_reg && out_valid)
        else $error("full buffer lost its head entry");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_w <= SAT_ONE) && (quat_w >= -SAT_ONE)
                   && (quat_x <= SAT_ONE) && (quat_x >= -SAT_ONE)
                   && (quat_y <= SAT_ONE) && (quat_y >= -SAT_ONE)
                   && (quat_z <= SAT_ONE) && (quat_z >= -SAT_ONE))
        else $error("quaternion component outside +-1.0");

endmodule
`default_nettype wire
